@@ design/hpwt_pkg.sv @@
package hpwt_pkg;

  typedef enum logic [2:0] {
    PH_A     = 3'd0,
    PH_C1    = 3'd1,
    PH_C2    = 3'd2,
    PH_D     = 3'd3,
    PH_E     = 3'd4,
    PH_F     = 3'd5,
    PH_G     = 3'd6,
    PH_OTHER = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    REG_DELAY_NOT_OK     = 2'd0,
    REG_DELAY_HOT_START  = 2'd1,
    REG_DELAY_COLD_START = 2'd2
  } reg_index_t;

  localparam int DELAY_W = 8;
  localparam int COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_CAP = 12'd2559;

  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [COUNT_W-1:0] count_t;

  function automatic logic in_afg(input phase_t p);
    return (p == PH_A) || (p == PH_F) || (p == PH_G);
  endfunction

  function automatic count_t times_ten(input delay_t d);
    return {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
  endfunction

endpackage

@@ design/heater_phase_warmup_timer.sv @@
// Channel   Signals                                      Direction
// -------   ------------------------------------------   ---------
// in        in_valid, in_ready, heater_phase             input
// out       out_valid, out_ready, heat_ok, time_left,    output
//           sensor_ready
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data    input
//
// One transaction per cycle sustained while the output is not stalled; a result
// passes through the input register, then the result register.
// The timer and flag state update in the same cycle as the result register.
// rst is synchronous and clears all control and timer state; delays reset to 0.
// A stalled output holds both stages; cfg_ready is always high.
module heater_phase_warmup_timer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              heater_phase,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    heat_ok,
  output logic [11:0]             time_left,
  output logic                    sensor_ready,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  hpwt_pkg::delay_t        cfg_data
);
  import hpwt_pkg::*;

  delay_t delay_not_ok;
  delay_t delay_hot_start;
  delay_t delay_cold_start;

  logic   in_reg_valid;
  phase_t in_reg_phase;

  phase_t last_phase;
  logic   last_start;
  count_t countdown;
  logic   ok_flag;
  logic   ready_flag;

  phase_t last_phase_next;
  logic   last_start_next;
  count_t countdown_next;
  logic   ok_flag_next;
  logic   ready_flag_next;

  logic   advance;
  logic   start;
  count_t duration;
  count_t count_dec;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_not_ok     <= '0;
      delay_hot_start  <= '0;
      delay_cold_start <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DELAY_NOT_OK:     delay_not_ok     <= cfg_data;
        REG_DELAY_HOT_START:  delay_hot_start  <= cfg_data;
        REG_DELAY_COLD_START: delay_cold_start <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    start = ((in_reg_phase == PH_E) &&
             ((last_phase == PH_C1) || (last_phase == PH_C2) ||
              (last_phase == PH_D)  || (last_phase == PH_A))) ||
            (in_afg(in_reg_phase) && !in_afg(last_phase));

    if (in_afg(in_reg_phase)) begin
      duration = times_ten(delay_not_ok);
    end else if (in_reg_phase == PH_E) begin
      duration = (last_phase == PH_A) ? times_ten(delay_hot_start)
                                      : times_ten(delay_cold_start);
    end else begin
      duration = '0;
    end

    count_dec = countdown - count_t'(1);

    countdown_next = countdown;
    ok_flag_next   = ok_flag;
    if (!last_start && start) begin
      countdown_next = duration;
      ok_flag_next   = (duration == '0);
    end else if (countdown != '0) begin
      countdown_next = (count_dec > COUNT_CAP) ? COUNT_CAP : count_dec;
      ok_flag_next   = (count_dec == '0);
    end

    ready_flag_next = ready_flag;
    if (!ok_flag && ok_flag_next) begin
      ready_flag_next = !in_afg(in_reg_phase);
    end

    last_phase_next = in_reg_phase;
    last_start_next = start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
      last_phase   <= PH_A;
      last_start   <= 1'b0;
      countdown    <= '0;
      ok_flag      <= 1'b0;
      ready_flag   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_reg_valid <= in_valid;
        in_reg_phase <= phase_t'(heater_phase);
      end
      if (advance) begin
        out_valid <= in_reg_valid;
        if (in_reg_valid) begin
          last_phase   <= last_phase_next;
          last_start   <= last_start_next;
          countdown    <= countdown_next;
          ok_flag      <= ok_flag_next;
          ready_flag   <= ready_flag_next;
          heat_ok      <= ok_flag_next;
          time_left    <= countdown_next;
          sensor_ready <= ready_flag_next;
        end
      end
    end
  end

endmodule
